@@ hw/rtl/sdtq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// Entry layout, result beat layout, arithmetic unit codes and field widths.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int unsigned DL_W    = 48;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned NEXT_W  = 32;
  localparam int unsigned KIND_W  = 2;
  // operand width of the shared unit: one headroom bit over a deadline
  localparam int unsigned OP_W    = DL_W + 1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd200;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_RUN    = 2'd2
  } kind_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  val;
    logic              fired;
    logic              found;
    logic              full;
    logic [NEXT_W-1:0] next;
    logic              last;
  } res_t;

endpackage

@@ hw/rtl/sdtq_mem.sv @@
// ----------------------------------------------------------------------------
// sdtq_mem: timer entry store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdtq_mem import sdtq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sdtq_alu.sv @@
// ----------------------------------------------------------------------------
// sdtq_alu: shared add/subtract unit
// Deadline sums, limits, ordering compares and time differences.
// ----------------------------------------------------------------------------
module sdtq_alu import sdtq_pkg::*; (
  input  alu_op_e         op_i,
  input  logic [OP_W-1:0] a_i,
  input  logic [OP_W-1:0] b_i,
  output logic [OP_W:0]   res_o
);

  // top bit is carry on add, borrow (a < b) on subtract
  always_comb begin
    case (op_i)
      ALU_ADD: res_o = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: res_o = {1'b0, a_i} - {1'b0, b_i};
      default: res_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/sorted_deadline_timer_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_core: sorted timer queue with iterative engine
// Holds up to DEPTH timers in ascending deadline order in a single-port-pair
// memory and serves schedule, cancel and run commands one at a time.
// ----------------------------------------------------------------------------
// Usage: issue a command by raising start while busy is low; the command is
// taken on that edge and busy stays high until its work is done. Each result
// beat appears on the result ports for exactly one cycle with res_valid_o
// high and must be captured then: there is no back-pressure. Every command
// but kind code 3 ends with a beat carrying last_o. A schedule runs the
// deadline sum and id scan, then the full check, then the insertion walk; a
// cancel runs the id scan alone. When timers fired and entries remain, a
// compaction walk follows the last beat with busy still high. The walks read
// one entry per cycle through the memory's single read port. Kind code 3 is
// taken and ignored. tolerance_us may be written only while the queue is not
// busy: cfg_ready_o is the inverse of busy.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_core import sdtq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command beat
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [ID_W-1:0]           event_id_i,
  input  logic signed [DELAY_W-1:0] delay_us_i,
  input  logic signed [VAL_W-1:0]   event_value_i,
  input  logic [DL_W-1:0]           now_us_i,
  // tolerance register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [TOL_W-1:0]          cfg_tolerance_us_i,
  // result beat
  output logic                      res_valid_o,
  output logic [ID_W-1:0]           fired_id_o,
  output logic signed [VAL_W-1:0]   fired_value_o,
  output logic                      fired_o,
  output logic                      found_o,
  output logic                      full_res_o,
  output logic [NEXT_W-1:0]         next_delay_us_o,
  output logic                      last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SDL    = 10'b00_0000_0010,  // deadline = now + clamped delay
    S_SCAN   = 10'b00_0000_0100,  // id search, closes the gap behind a hit
    S_INSD   = 10'b00_0000_1000,  // full check
    S_INS    = 10'b00_0001_0000,  // insertion walk, top down
    S_RSTART = 10'b00_0010_0000,
    S_RLIM   = 10'b00_0100_0000,  // expiry limit from head or now
    S_RSCAN  = 10'b00_1000_0000,  // fire expired prefix
    S_RNEXT  = 10'b01_0000_0000,  // time to next deadline
    S_COMP   = 10'b10_0000_0000   // shift survivors down by fired count
  } state_e;

  state_e state_q, state_d;

  // command latch
  logic               sched_q, sched_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [DL_W-1:0]    now_q, now_d;

  // walk state
  logic [CNT_W-1:0]   cnt_q, cnt_d;    // live entries
  logic [CNT_W-1:0]   ptr_q, ptr_d;    // read issue pointer / fill slot
  logic               pv_q, pv_d;      // read data in flight is valid
  logic [CNT_W-1:0]   pidx_q, pidx_d;  // index of that read data
  logic [CNT_W-1:0]   k_q, k_d;        // fired count
  logic               found_q, found_d;
  logic [DL_W-1:0]    dl_q, dl_d;
  logic [OP_W-1:0]    lim_q, lim_d;
  logic [DL_W-1:0]    t_q, t_d;
  logic [DL_W-1:0]    head_q, head_d;

  logic [TOL_W-1:0]   tol_q;
  res_t               res_q, res_d;

  // memory and shared unit hookup
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  entry_t             mem_wdata, rd_e, new_e;
  alu_op_e            alu_op;
  logic [OP_W-1:0]    alu_a, alu_b;
  logic [OP_W:0]      alu_res;

  logic [CNT_W-1:0]   pidx_m1, ptr_m1, ptr_m2, ptr_pk, rem;
  logic [DELAY_W-1:0] delay_clamp;
  logic [DL_W-1:0]    run_t;
  logic [NEXT_W-1:0]  next_sat;
  logic               more;

  sdtq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_e)
  );

  sdtq_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  assign pidx_m1     = pidx_q - CNT_W'(1);
  assign ptr_m1      = ptr_q - CNT_W'(1);
  assign ptr_m2      = ptr_q - CNT_W'(2);
  assign ptr_pk      = ptr_q + k_q;
  assign rem         = cnt_q - k_q;
  assign more        = (ptr_q < cnt_q);
  assign delay_clamp = delay_q[DELAY_W-1] ? '0 : delay_q;
  // run with now zero takes the head deadline as the time base
  assign run_t       = (now_q == '0) ? rd_e.dl : now_q;
  assign new_e       = '{dl: dl_q, id: id_q, val: val_q};

  // head minus time base, saturated to the result width; borrow gives zero
  assign next_sat = alu_res[OP_W]              ? '0 :
                    (|alu_res[DL_W-1:NEXT_W]) ? '1 : alu_res[NEXT_W-1:0];

  always_comb begin
    state_d   = state_q;
    sched_d   = sched_q;
    id_d      = id_q;
    delay_d   = delay_q;
    val_d     = val_q;
    now_d     = now_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pv_d      = pv_q;
    pidx_d    = pidx_q;
    k_d       = k_q;
    found_d   = found_q;
    dl_d      = dl_q;
    lim_d     = lim_q;
    t_d       = t_q;
    head_d    = head_q;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_e;
    mem_re    = 1'b0;
    mem_raddr = '0;
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          id_d    = event_id_i;
          delay_d = delay_us_i;
          val_d   = event_value_i;
          now_d   = now_us_i;
          ptr_d   = '0;
          pv_d    = 1'b0;
          found_d = 1'b0;
          case (kind_e'(kind_i))
            KIND_SCHED: begin
              sched_d = 1'b1;
              state_d = S_SDL;
            end
            KIND_CANCEL: begin
              sched_d = 1'b0;
              state_d = S_SCAN;
            end
            KIND_RUN: begin
              state_d = S_RSTART;
            end
            default: ;
          endcase
        end
      end

      S_SDL: begin
        alu_op  = ALU_ADD;
        alu_a   = {1'b0, now_q};
        alu_b   = OP_W'(delay_clamp);
        dl_d    = alu_res[DL_W] ? '1 : alu_res[DL_W-1:0];
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[IDX_W-1:0];
          pv_d      = 1'b1;
          pidx_d    = ptr_q;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = pidx_m1[IDX_W-1:0];
            mem_wdata = rd_e;
          end else if (rd_e.id == id_q) begin
            found_d = 1'b1;
          end
        end
        if (!more && !pv_q) begin
          if (found_q) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
          if (sched_q) begin
            state_d = S_INSD;
          end else begin
            res_d.valid = 1'b1;
            res_d.found = found_q;
            res_d.last  = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end

      S_INSD: begin
        if (cnt_q == CNT_W'(DEPTH)) begin
          res_d.valid = 1'b1;
          res_d.found = found_q;
          res_d.full  = 1'b1;
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ptr_d   = cnt_q;
          pv_d    = 1'b0;
          state_d = S_INS;
        end
      end

      S_INS: begin
        // ptr_q is the hole; entries above the new deadline move up into it
        alu_op = ALU_SUB;
        alu_a  = {1'b0, dl_q};
        alu_b  = {1'b0, rd_e.dl};
        if (pv_q && alu_res[OP_W]) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q[IDX_W-1:0];
          mem_wdata = rd_e;
          ptr_d     = ptr_m1;
          if (ptr_q > CNT_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_m2[IDX_W-1:0];
            pv_d      = 1'b1;
          end else begin
            pv_d = 1'b0;
          end
        end else if (pv_q || ptr_q == '0) begin
          mem_we      = 1'b1;
          mem_waddr   = ptr_q[IDX_W-1:0];
          mem_wdata   = new_e;
          cnt_d       = cnt_q + CNT_W'(1);
          pv_d        = 1'b0;
          res_d.valid = 1'b1;
          res_d.found = found_q;
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_m1[IDX_W-1:0];
          pv_d      = 1'b1;
        end
      end

      S_RSTART: begin
        if (cnt_q == '0) begin
          res_d.valid = 1'b1;
          res_d.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = S_RLIM;
        end
      end

      S_RLIM: begin
        alu_op  = ALU_ADD;
        alu_a   = {1'b0, run_t};
        alu_b   = OP_W'(tol_q);
        lim_d   = alu_res[OP_W-1:0];
        t_d     = run_t;
        ptr_d   = '0;
        pv_d    = 1'b0;
        k_d     = '0;
        state_d = S_RSCAN;
      end

      S_RSCAN: begin
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[IDX_W-1:0];
          pv_d      = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          pv_d = 1'b0;
        end
        alu_op = ALU_SUB;
        alu_a  = lim_q;
        alu_b  = {1'b0, rd_e.dl};
        if (pv_q) begin
          if (!alu_res[OP_W]) begin
            res_d.valid = 1'b1;
            res_d.id    = rd_e.id;
            res_d.val   = rd_e.val;
            res_d.fired = 1'b1;
            k_d         = k_q + CNT_W'(1);
          end else begin
            head_d  = rd_e.dl;
            state_d = S_RNEXT;
          end
        end else if (!more) begin
          state_d = S_RNEXT;
        end
      end

      S_RNEXT: begin
        alu_op      = ALU_SUB;
        alu_a       = {1'b0, head_q};
        alu_b       = {1'b0, t_q};
        res_d.valid = 1'b1;
        res_d.last  = 1'b1;
        res_d.next  = (now_q != '0 && rem != '0) ? next_sat : '0;
        cnt_d       = rem;
        ptr_d       = '0;
        pv_d        = 1'b0;
        if (k_q != '0 && rem != '0) begin
          state_d = S_COMP;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_COMP: begin
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_pk[IDX_W-1:0];
          pv_d      = 1'b1;
          pidx_d    = ptr_q;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q[IDX_W-1:0];
          mem_wdata = rd_e;
        end
        if (!more && !pv_q) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      tol_q   <= TOL_RESET;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      res_q   <= res_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_tolerance_us_i;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    sched_q     <= sched_d;
    id_q        <= id_d;
    delay_q     <= delay_d;
    val_q       <= val_d;
    now_q       <= now_d;
    ptr_q       <= ptr_d;
    pidx_q      <= pidx_d;
    k_q         <= k_d;
    found_q     <= found_d;
    dl_q        <= dl_d;
    lim_q       <= lim_d;
    t_q         <= t_d;
    head_q      <= head_d;
  end

  assign res_valid_o     = res_q.valid;
  assign fired_id_o      = res_q.id;
  assign fired_value_o   = $signed(res_q.val);
  assign fired_o         = res_q.fired;
  assign found_o         = res_q.found;
  assign full_res_o      = res_q.full;
  assign next_delay_us_o = res_q.next;
  assign last_o          = res_q.last;

endmodule

@@ bench/sorted_deadline_timer_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_core_tb: self-checking bench for the timer queue
// Drives schedule, cancel and run commands with random gaps and checks every
// result beat against a cycle-free model of the sorted queue. The directed
// part covers the corner cases. Random phases then run at several tolerances.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_core_tb;
  import sdtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  // kind code that the block takes and drops without a result
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  // walks read one entry per cycle; this covers a compaction after any beat
  localparam int unsigned DRAIN_CYCLES = 4 * DEPTH + 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 44;
  localparam logic [DL_W-1:0] DL_MAX   = '1;

  // one result beat as seen on the result ports
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  value;
    logic              fired;
    logic              found;
    logic              full;
    logic [NEXT_W-1:0] next_delay;
    logic              last;
  } timer_beat_t;

  // Queue model plus the store of beats still owed by the block.
  class timer_scoreboard;
    logic [DL_W-1:0]  dl_q  [DEPTH];
    logic [ID_W-1:0]  id_q  [DEPTH];
    logic [VAL_W-1:0] val_q [DEPTH];
    int unsigned      count;
    logic [TOL_W-1:0] tolerance;
    timer_beat_t      owed[$];
    int unsigned      errors;

    function new();
      count     = 0;
      tolerance = TOL_RESET;
      errors    = 0;
    endfunction

    function void set_tolerance(logic [TOL_W-1:0] v);
      tolerance = v;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // close the gap at slot i
    function void take_out(int unsigned i);
      for (int unsigned j = i; j + 1 < count; j++) begin
        dl_q[j]  = dl_q[j+1];
        id_q[j]  = id_q[j+1];
        val_q[j] = val_q[j+1];
      end
      count--;
    endfunction

    function logic remove_id(logic [ID_W-1:0] eid);
      for (int unsigned i = 0; i < count; i++) begin
        if (id_q[i] == eid) begin
          take_out(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // insert after every entry with an equal deadline
    function void place(logic [DL_W-1:0] dl, logic [ID_W-1:0] eid, logic [VAL_W-1:0] v);
      int unsigned pos;
      pos = 0;
      while (pos < count && dl_q[pos] <= dl) pos++;
      for (int unsigned j = count; j > pos; j--) begin
        dl_q[j]  = dl_q[j-1];
        id_q[j]  = id_q[j-1];
        val_q[j] = val_q[j-1];
      end
      dl_q[pos]  = dl;
      id_q[pos]  = eid;
      val_q[pos] = v;
      count++;
    endfunction

    function void note_command(logic [KIND_W-1:0] k, logic [ID_W-1:0] eid,
                               logic [DELAY_W-1:0] dly, logic [VAL_W-1:0] v,
                               logic [DL_W-1:0] now);
      logic [DL_W:0]     sum;
      logic [DL_W:0]     limit;
      logic [DL_W-1:0]   dl;
      logic [DL_W-1:0]   t;
      logic [DL_W-1:0]   d;
      logic [NEXT_W-1:0] nxt;
      logic              hit;
      logic              full;
      case (k)
        KIND_SCHED: begin
          sum  = {1'b0, now} + (dly[DELAY_W-1] ? '0 : {{(DL_W+1-DELAY_W){1'b0}}, dly});
          dl   = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
          hit  = remove_id(eid);
          full = (count >= DEPTH);
          if (!full) place(dl, eid, v);
          owed.push_back('{'0, '0, 1'b0, hit, full, '0, 1'b1});
        end
        KIND_CANCEL: begin
          hit = remove_id(eid);
          owed.push_back('{'0, '0, 1'b0, hit, 1'b0, '0, 1'b1});
        end
        KIND_RUN: begin
          nxt = '0;
          if (count != 0) begin
            t     = (now == '0) ? dl_q[0] : now;
            limit = {1'b0, t} + (DL_W+1)'(tolerance);
            while (count != 0 && {1'b0, dl_q[0]} <= limit) begin
              owed.push_back('{id_q[0], val_q[0], 1'b1, 1'b0, 1'b0, '0, 1'b0});
              take_out(0);
            end
            if (now != '0 && count != 0) begin
              d   = (dl_q[0] > t) ? dl_q[0] - t : '0;
              nxt = (d > 48'hFFFF_FFFF) ? '1 : d[NEXT_W-1:0];
            end
          end
          owed.push_back('{'0, '0, 1'b0, 1'b0, 1'b0, nxt, 1'b1});
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(timer_beat_t got);
      timer_beat_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing actual %p",
                 $time, got);
        return;
      end
      want = owed.pop_front();
      check_field("fired_id", 64'(want.id), 64'(got.id));
      check_field("fired_value", 64'(want.value), 64'(got.value));
      check_field("fired", 64'(want.fired), 64'(got.fired));
      check_field("found", 64'(want.found), 64'(got.found));
      check_field("full_res", 64'(want.full), 64'(got.full));
      check_field("next_delay_us", 64'(want.next_delay), 64'(got.next_delay));
      check_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [KIND_W-1:0]         kind_i;
  logic [ID_W-1:0]           event_id_i;
  logic signed [DELAY_W-1:0] delay_us_i;
  logic signed [VAL_W-1:0]   event_value_i;
  logic [DL_W-1:0]           now_us_i;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [TOL_W-1:0]          cfg_tolerance_us_i;
  logic                      res_valid_o;
  logic [ID_W-1:0]           fired_id_o;
  logic signed [VAL_W-1:0]   fired_value_o;
  logic                      fired_o;
  logic                      found_o;
  logic                      full_res_o;
  logic [NEXT_W-1:0]         next_delay_us_o;
  logic                      last_o;

  timer_scoreboard sb = new();
  int unsigned     cycles = 0;
  logic            steady;     // no sender gaps while set
  logic [DL_W-1:0] sim_now;    // running time of the random phases

  sorted_deadline_timer_queue_core #(.DEPTH(DEPTH)) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .event_id_i         (event_id_i),
    .delay_us_i         (delay_us_i),
    .event_value_i      (event_value_i),
    .now_us_i           (now_us_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_tolerance_us_i (cfg_tolerance_us_i),
    .res_valid_o        (res_valid_o),
    .fired_id_o         (fired_id_o),
    .fired_value_o      (fired_value_o),
    .fired_o            (fired_o),
    .found_o            (found_o),
    .full_res_o         (full_res_o),
    .next_delay_us_o    (next_delay_us_o),
    .last_o             (last_o)
  );

  always #5ns clk_i = ~clk_i;

  // Monitor: everything is sampled at the rising edge, where inputs driven at
  // the falling edge are settled and DUT register updates are not yet visible.
  // Result beats are checked before a command taken on the same edge is noted,
  // since those beats belong to the command before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o)
        sb.check_beat('{fired_id_o, fired_value_o, fired_o, found_o, full_res_o,
                        next_delay_us_o, last_o});
      if (start && !busy)
        sb.note_command(kind_i, event_id_i, delay_us_i, event_value_i, now_us_i);
      if (cfg_valid_i && cfg_ready_o)
        sb.set_tolerance(cfg_tolerance_us_i);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One command beat. A random gap may come first; otherwise start stays high
  // straight from the previous beat. Returns at the edge that takes the beat.
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] eid,
                          input logic [DELAY_W-1:0] dly, input logic [VAL_W-1:0] v,
                          input logic [DL_W-1:0] now);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 19) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start         = 1'b1;
    kind_i        = k;
    event_id_i    = eid;
    delay_us_i    = dly;
    event_value_i = v;
    now_us_i      = now;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i        = 1'b1;
    cfg_tolerance_us_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stop issuing, wait for every owed beat, then let any trailing compaction
  // walk finish (a dropped kind 3 command leaves nothing to wait on).
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly coherent traffic around a running clock: schedules a few ms out,
  // runs that advance time, cancels on a small id pool so that reschedules,
  // hits and a full queue all happen. A few items use wild ids, negative or
  // huge delays and random 48-bit times.
  task automatic random_phase(input int unsigned n_items);
    int unsigned        done;
    int unsigned        pick;
    logic [ID_W-1:0]    eid;
    logic [DELAY_W-1:0] dly;
    logic [DL_W-1:0]    now;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      eid  = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(23));
      now  = ($urandom_range(19) == 0) ? DL_W'({$urandom, $urandom}) : sim_now;
      if (pick < 45) begin
        case ($urandom_range(9))
          0:       dly = $urandom | 32'h8000_0000;
          1:       dly = $urandom;
          default: dly = $urandom_range(3000);
        endcase
        send_cmd(KIND_SCHED, eid, dly, $urandom, now);
        done++;
      end else if (pick < 65) begin
        send_cmd(KIND_CANCEL, eid, $urandom, $urandom, now);
        done++;
      end else if (pick < 96) begin
        sim_now = sim_now + DL_W'($urandom_range(1500));
        if ($urandom_range(9) == 0)
          now = '0;
        else if (now != DL_W'({$urandom, $urandom}) && $urandom_range(29) != 0)
          now = sim_now;
        send_cmd(KIND_RUN, eid, $urandom, $urandom, now);
        done++;
      end else begin
        send_cmd(KIND_NONE, eid, $urandom, $urandom, now);
      end
    end
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan [5];
    int unsigned      i;

    rst_ni             = 1'b0;
    start              = 1'b0;
    kind_i             = '0;
    event_id_i         = '0;
    delay_us_i         = '0;
    event_value_i      = '0;
    now_us_i           = '0;
    cfg_valid_i        = 1'b0;
    cfg_tolerance_us_i = '0;
    steady             = 1'b0;
    sim_now            = 48'h0000_FFFF_0000;   // starts just below the 32-bit boundary
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, at the reset tolerance of 200 us.
    send_cmd(KIND_RUN, 8'd0, '0, '0, 48'd1000);                  // empty queue
    send_cmd(KIND_SCHED, 8'd0, -32'sd5, 32'h7FFF_FFFF, 48'd1000); // negative delay
    send_cmd(KIND_SCHED, 8'd255, 32'h7FFF_FFFF, 32'h0, DL_MAX);  // deadline saturates
    send_cmd(KIND_SCHED, 8'd7, 32'd500, 32'h8000_0000, 48'd1000);
    send_cmd(KIND_SCHED, 8'd8, 32'd500, 32'hFFFF_FFFF, 48'd1000); // equal deadline
    send_cmd(KIND_SCHED, 8'd7, 32'd100, 32'h1, 48'd1000);        // reschedule hits
    send_cmd(KIND_RUN, 8'd0, '0, '0, 48'd1100);                  // fires two
    send_cmd(KIND_RUN, 8'd0, '0, '0, 48'd0);                     // now from head
    send_cmd(KIND_RUN, 8'd0, '0, '0, 48'd2000);                  // next saturates
    for (i = 0; i < 15; i++)
      send_cmd(KIND_SCHED, ID_W'(16 + i), DELAY_W'(i * 40), $urandom, 48'd2000);
    send_cmd(KIND_SCHED, 8'd99, 32'd10, 32'h5, 48'd2000);        // queue full
    send_cmd(KIND_SCHED, 8'd16, 32'd0, 32'h6, 48'd2000);         // full but id present
    send_cmd(KIND_NONE, 8'd16, '0, '0, 48'd2000);                // dropped
    send_cmd(KIND_CANCEL, 8'd200, '0, '0, 48'd2000);             // cancel misses
    send_cmd(KIND_RUN, 8'd0, '0, '0, DL_MAX);                    // fires all 16
    settle();

    // Random phases, each at its own tolerance; the third runs without gaps.
    tol_plan = '{16'd0, 16'hFFFF, TOL_W'($urandom), 16'd200, TOL_W'($urandom)};
    for (i = 0; i < 5; i++) begin
      write_tolerance(tol_plan[i]);
      steady = (i == 2);
      random_phase(PHASE_ITEMS);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sorted_deadline_timer_queue_core.f @@
hw/rtl/sdtq_pkg.sv
hw/rtl/sdtq_mem.sv
hw/rtl/sdtq_alu.sv
hw/rtl/sorted_deadline_timer_queue_core.sv
bench/sorted_deadline_timer_queue_core_tb.sv
